### design/sec_pkg.sv
// Shared types and constants for the sampled edge counter.
// Used by the register block, the word scanner and the top level.
`timescale 1ns / 1ps

package sec_pkg;

    // Field widths.
    localparam int WORD_W = 32;
    localparam int CNT_W  = 20;
    localparam int POS_W  = 20;
    localparam int IDX_W  = 16;
    localparam int BIT_W  = 5;
    localparam int NUM_W  = 6;

    // Output payload: 82 bits of fields padded to 88 bits.
    localparam int OUT_FIELDS_W = 82;
    localparam int OUT_DATA_W   = 88;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes (paddr bit 2 selects the register).
    localparam logic REG_CAPTURE_WORDS = 1'b0;
    localparam logic REG_MARKED_EDGE   = 1'b1;

    // Reset values of the registers.
    localparam logic [IDX_W-1:0] CAPTURE_WORDS_RST = 16'd24000;
    localparam logic [CNT_W-1:0] MARKED_EDGE_RST   = 20'd10;

    // Default maximum capture length and the saturation value of the count.
    localparam int               MAX_WORDS_DEF = 32768;
    localparam logic [CNT_W-1:0] CNT_MAX       = 20'hFFFFF;

    // Summary of the rising edges found in one sample word.
    typedef struct packed {
        logic [NUM_W-1:0] edge_num;
        logic [BIT_W-1:0] low_bit;
        logic [BIT_W-1:0] high_bit;
        logic             mark_hit;
        logic [BIT_W-1:0] mark_bit;
        logic [CNT_W:0]   total_sum;
    } scan_t;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [IDX_W-1:0] capture_words;
        logic [CNT_W-1:0] marked_edge_number;
    } cfg_t;

endpackage

### design/sampled_edge_counter.sv
// Sampled edge counter: counts rising edges over a capture of sample words.
// The result register driving m_tvalid is loaded from the input register holding
// a capture's last word. Throughput: one word per cycle unless the result stalls,
// set by the single input register before the word scanner and result register.
// Reset (aresetn, synchronous) clears the capture state and both handshake
// stages and restores capture_words to 24000 and marked_edge_number to 10.
`timescale 1ns / 1ps

module sampled_edge_counter #(
    parameter int MAX_WORDS = sec_pkg::MAX_WORDS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sec_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sec_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sec_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // Sample words: [31:0] sample_word.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sec_pkg::WORD_W-1:0]        s_tdata,
    // Results: [19:0] edge_count, [20] any_edge, [40:21] first_edge_pos,
    // [60:41] edge_span, [61] marked_found, [81:62] marked_edge_pos, [87:82] zero.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sec_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam logic [sec_pkg::IDX_W:0] MAX_LEN = (sec_pkg::IDX_W+1)'(MAX_WORDS);
    localparam logic [sec_pkg::IDX_W:0] MIN_LEN = (sec_pkg::IDX_W+1)'(2);
    localparam int BIT_SH = sec_pkg::BIT_W;

    sec_pkg::cfg_t  cfg;
    sec_pkg::scan_t scan;

    logic                        in_valid_reg;
    logic [sec_pkg::WORD_W-1:0]  in_word_reg;
    logic                        out_valid_reg;
    logic [sec_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [sec_pkg::IDX_W-1:0]   word_index_reg;
    logic                        prev_bit_reg;
    logic [sec_pkg::CNT_W-1:0]   edge_total_reg;
    logic [sec_pkg::POS_W-1:0]   first_pos_reg;
    logic [sec_pkg::POS_W-1:0]   latest_pos_reg;
    logic [sec_pkg::POS_W-1:0]   marked_pos_reg;
    logic                        marked_seen_reg;

    logic [sec_pkg::CNT_W-1:0]   edge_total_next;
    logic [sec_pkg::POS_W-1:0]   first_pos_next;
    logic [sec_pkg::POS_W-1:0]   latest_pos_next;
    logic [sec_pkg::POS_W-1:0]   marked_pos_next;
    logic                        marked_seen_next;

    logic [sec_pkg::IDX_W:0]     len_eff;
    logic [sec_pkg::IDX_W-1:0]   last_index;
    logic                        out_free;
    logic                        advance;
    logic                        discard;
    logic                        capture_end;
    logic                        any_next;
    logic [sec_pkg::POS_W-BIT_SH-1:0] word_pos;

    sec_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sec_word_scan u_scan (
        .word       (in_word_reg),
        .prev_bit   (prev_bit_reg),
        .seed       (word_index_reg == sec_pkg::IDX_W'(1)),
        .edge_total (edge_total_reg),
        .marked_num (cfg.marked_edge_number),
        .scan       (scan)
    );

    // Handshake: the input stage moves on whenever the result register is
    // free or being emptied in the same cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Effective capture length, clamped to [2, MAX_WORDS].
    always_comb begin
        len_eff = {1'b0, cfg.capture_words};
        if (len_eff < MIN_LEN) begin
            len_eff = MIN_LEN;
        end
        if (len_eff > MAX_LEN) begin
            len_eff = MAX_LEN;
        end
    end
    assign last_index = sec_pkg::IDX_W'(len_eff - (sec_pkg::IDX_W+1)'(1));

    assign discard     = (word_index_reg == '0);
    assign capture_end = !discard && (word_index_reg >= last_index);
    assign word_pos    = word_index_reg[sec_pkg::POS_W-BIT_SH-1:0];

    // Capture state update for the word in the input register.
    always_comb begin
        edge_total_next  = scan.total_sum[sec_pkg::CNT_W] ? sec_pkg::CNT_MAX
                                                         : scan.total_sum[sec_pkg::CNT_W-1:0];
        first_pos_next   = first_pos_reg;
        latest_pos_next  = latest_pos_reg;
        marked_pos_next  = marked_pos_reg;
        marked_seen_next = marked_seen_reg;
        if (scan.edge_num != '0) begin
            latest_pos_next = {word_pos, scan.high_bit};
            if (edge_total_reg == '0) begin
                first_pos_next = {word_pos, scan.low_bit};
            end
        end
        if (scan.mark_hit) begin
            marked_pos_next  = {word_pos, scan.mark_bit};
            marked_seen_next = 1'b1;
        end
    end

    assign any_next = (edge_total_next != '0);

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= s_tdata;
        end
    end

    // Capture state: cleared at the end of every capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_index_reg  <= '0;
            prev_bit_reg    <= 1'b0;
            edge_total_reg  <= '0;
            first_pos_reg   <= '0;
            latest_pos_reg  <= '0;
            marked_pos_reg  <= '0;
            marked_seen_reg <= 1'b0;
        end else if (advance) begin
            if (discard) begin
                word_index_reg <= sec_pkg::IDX_W'(1);
            end else if (capture_end) begin
                word_index_reg  <= '0;
                prev_bit_reg    <= 1'b0;
                edge_total_reg  <= '0;
                first_pos_reg   <= '0;
                latest_pos_reg  <= '0;
                marked_pos_reg  <= '0;
                marked_seen_reg <= 1'b0;
            end else begin
                word_index_reg  <= word_index_reg + sec_pkg::IDX_W'(1);
                prev_bit_reg    <= in_word_reg[sec_pkg::WORD_W-1];
                edge_total_reg  <= edge_total_next;
                first_pos_reg   <= first_pos_next;
                latest_pos_reg  <= latest_pos_next;
                marked_pos_reg  <= marked_pos_next;
                marked_seen_reg <= marked_seen_next;
            end
        end
    end

    // Result register: loaded on the last word of a capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && capture_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && capture_end) begin
            out_data_reg <= {
                {(sec_pkg::OUT_DATA_W-sec_pkg::OUT_FIELDS_W){1'b0}},
                marked_seen_next ? marked_pos_next : {sec_pkg::POS_W{1'b0}},
                marked_seen_next,
                any_next ? (latest_pos_next - first_pos_next) : {sec_pkg::POS_W{1'b0}},
                any_next ? first_pos_next : {sec_pkg::POS_W{1'b0}},
                any_next,
                edge_total_next
            };
        end
    end

    // A capture with no edges reports zero positions.
    a_no_edge_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[19:0] == '0)) |->
            (!m_tdata[20] && (m_tdata[40:21] == '0) && (m_tdata[60:41] == '0)))
        else $error("result without edges carries nonzero positions");

    // The marked edge can only be found when some edge was counted.
    a_marked_needs_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[61]) |-> m_tdata[20])
        else $error("marked edge found in a capture without edges");

    // The input side stalls only behind a held word and a stalled result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a stalled result");

    // A discarded first word never produces a result.
    a_discard_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && discard && !out_valid_reg) |=> !out_valid_reg)
        else $error("result produced by a discarded word");

endmodule

### design/sec_apb_regs.sv
// Configuration registers of the sampled edge counter behind an APB-style port.
// Depends on sec_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module sec_apb_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sec_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sec_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sec_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output sec_pkg::cfg_t                    cfg
);

    logic [sec_pkg::IDX_W-1:0] capture_words_reg;
    logic [sec_pkg::CNT_W-1:0] marked_edge_reg;
    logic                      wr_en;
    logic                      reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes complete in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_words_reg <= sec_pkg::CAPTURE_WORDS_RST;
            marked_edge_reg   <= sec_pkg::MARKED_EDGE_RST;
        end else if (wr_en) begin
            if (reg_sel == sec_pkg::REG_CAPTURE_WORDS) begin
                capture_words_reg <= pwdata[sec_pkg::IDX_W-1:0];
            end else begin
                marked_edge_reg <= pwdata[sec_pkg::CNT_W-1:0];
            end
        end
    end

    // Read data is a plain mux of the two registers.
    always_comb begin
        if (reg_sel == sec_pkg::REG_CAPTURE_WORDS) begin
            prdata = {{(sec_pkg::APB_DATA_W-sec_pkg::IDX_W){1'b0}}, capture_words_reg};
        end else begin
            prdata = {{(sec_pkg::APB_DATA_W-sec_pkg::CNT_W){1'b0}}, marked_edge_reg};
        end
    end

    // Both registers leave as one configuration bundle.
    assign cfg = {capture_words_reg, marked_edge_reg};

endmodule

### design/sec_word_scan.sv
// Combinational scan of one sample word: edge mask, edge count, first and last
// edge bit, and the bit of the marked edge. Depends on sec_pkg.
`timescale 1ns / 1ps

module sec_word_scan (
    input  logic [sec_pkg::WORD_W-1:0] word,
    input  logic                       prev_bit,
    input  logic                       seed,
    input  logic [sec_pkg::CNT_W-1:0]  edge_total,
    input  logic [sec_pkg::CNT_W-1:0]  marked_num,
    output sec_pkg::scan_t             scan
);

    logic                       prev_eff;
    logic [sec_pkg::WORD_W-1:0] edges;
    logic [sec_pkg::NUM_W-1:0]  prefix [sec_pkg::WORD_W];
    logic [sec_pkg::CNT_W-1:0]  mark_diff;
    logic [sec_pkg::NUM_W-1:0]  mark_rank;
    logic [sec_pkg::BIT_W-1:0]  low_bit;
    logic [sec_pkg::BIT_W-1:0]  high_bit;
    logic [sec_pkg::BIT_W-1:0]  mark_bit;

    // On the first kept word the earliest sample seeds the previous bit,
    // so bit 0 cannot be an edge there.
    assign prev_eff = seed ? word[0] : prev_bit;
    assign edges    = word & ~{word[sec_pkg::WORD_W-2:0], prev_eff};

    // Inclusive count of edges up to each bit, each an independent popcount.
    always_comb begin
        logic [sec_pkg::WORD_W-1:0] mask;
        for (int j = 0; j < sec_pkg::WORD_W; j++) begin
            mask      = {sec_pkg::WORD_W{1'b1}} >> (sec_pkg::WORD_W - 1 - j);
            prefix[j] = sec_pkg::NUM_W'($countones(edges & mask));
        end
    end

    assign scan.edge_num  = prefix[sec_pkg::WORD_W-1];
    assign scan.total_sum = {1'b0, edge_total} + (sec_pkg::CNT_W+1)'(scan.edge_num);

    // The marked edge falls in this word when its ordinal lies past the
    // running total and within the total plus this word's edges.
    assign mark_diff     = marked_num - edge_total;
    assign mark_rank     = mark_diff[sec_pkg::NUM_W-1:0];
    assign scan.mark_hit = (marked_num != '0) && (marked_num > edge_total) &&
                           ({1'b0, marked_num} <= scan.total_sum);

    // Lowest, highest and ranked edge bits.
    always_comb begin
        low_bit  = '0;
        high_bit = '0;
        mark_bit = '0;
        for (int j = sec_pkg::WORD_W - 1; j >= 0; j--) begin
            if (edges[j]) begin
                low_bit = sec_pkg::BIT_W'(j);
            end
        end
        for (int j = 0; j < sec_pkg::WORD_W; j++) begin
            if (edges[j]) begin
                high_bit = sec_pkg::BIT_W'(j);
            end
            if (edges[j] && (prefix[j] == mark_rank)) begin
                mark_bit = sec_pkg::BIT_W'(j);
            end
        end
    end

    assign scan.low_bit  = low_bit;
    assign scan.high_bit = high_bit;
    assign scan.mark_bit = mark_bit;

endmodule

### tb/tb_sampled_edge_counter.sv
// Self-checking testbench for the sampled edge counter: random and directed sample
// captures go in on the word stream and each capture summary is checked against a
// behavioral predictor kept in this file. Depends only on sec_pkg and the DUT.
`timescale 1ns / 1ps

module tb_sampled_edge_counter;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_WORDS     = sec_pkg::MAX_WORDS_DEF;

    localparam int WORD_W     = sec_pkg::WORD_W;
    localparam int CNT_W      = sec_pkg::CNT_W;
    localparam int POS_W      = sec_pkg::POS_W;
    localparam int IDX_W      = sec_pkg::IDX_W;
    localparam int APB_ADDR_W = sec_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = sec_pkg::APB_DATA_W;
    localparam int OUT_DATA_W = sec_pkg::OUT_DATA_W;

    // One capture summary as it travels on m_tdata, lowest field last.
    typedef struct packed {
        logic [5:0]       pad;
        logic [POS_W-1:0] marked_edge_pos;
        logic             marked_found;
        logic [POS_W-1:0] edge_span;
        logic [POS_W-1:0] first_edge_pos;
        logic             any_edge;
        logic [CNT_W-1:0] edge_count;
    } capture_summary_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata  = '0;   // [31:0] sample_word
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [19:0] edge_count, [20] any_edge, [40:21] first_edge_pos, [60:41] edge_span,
    // [61] marked_found, [81:62] marked_edge_pos, [87:82] zero
    logic [OUT_DATA_W-1:0] m_tdata;

    // Words waiting to be sent and capture summaries still to come.
    logic [WORD_W-1:0]     sample_queue[$];
    capture_summary_t      capture_summaries[$];

    // Predictor copy of the registers and of the capture state.
    logic [IDX_W-1:0]      cfg_capture_words = sec_pkg::CAPTURE_WORDS_RST;
    logic [CNT_W-1:0]      cfg_marked_edge   = sec_pkg::MARKED_EDGE_RST;
    logic [IDX_W-1:0]      next_word_index   = '0;
    logic                  prev_sample       = 1'b0;
    logic [CNT_W-1:0]      seen_edges        = '0;
    logic [POS_W-1:0]      first_edge_at     = '0;
    logic [POS_W-1:0]      latest_edge_at    = '0;
    logic [POS_W-1:0]      marked_edge_at    = '0;
    logic                  marked_hit        = 1'b0;

    int                    mismatch_count = 0;
    int                    cycle_count    = 0;
    int                    burst_left     = 0;
    int                    gap_left       = 0;
    int                    stall_cycles   = 0;
    logic [15:0]           stall_pattern  = 16'hFFFF;

    sampled_edge_counter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sampled_edge_counter: mismatch");
            $finish;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Capture length after clamping to the supported range.
    function automatic int effective_length();
        int len;
        len = cfg_capture_words;
        if (len < 2)
            len = 2;
        if (len > MAX_WORDS)
            len = MAX_WORDS;
        return len;
    endfunction

    // Number of words that complete the capture now in progress.
    function automatic int words_to_close();
        int len;
        len = effective_length();
        if (next_word_index + 1 >= len)
            return 1;
        return len - next_word_index;
    endfunction

    // Scans one accepted word and queues a summary when it closes the capture.
    task automatic scan_word(input logic [WORD_W-1:0] word);
        int               len;
        int               j;
        logic [31:0]      pos_full;
        logic [POS_W-1:0] pos;
        capture_summary_t summary;
        len = effective_length();
        if (next_word_index == 0) begin
            // The first word of a capture is thrown away.
            next_word_index = IDX_W'(1);
        end else begin
            if (next_word_index == 1)
                prev_sample = word[0];
            for (j = 0; j < WORD_W; j++) begin
                pos_full = next_word_index * 32 + j;
                pos = pos_full[POS_W-1:0];
                if (word[j] && !prev_sample) begin
                    if (seen_edges != sec_pkg::CNT_MAX) begin
                        seen_edges = CNT_W'(seen_edges + 1);
                        latest_edge_at = pos;
                        if (seen_edges == 1)
                            first_edge_at = pos;
                        if (cfg_marked_edge != 0 && seen_edges == cfg_marked_edge) begin
                            marked_edge_at = pos;
                            marked_hit = 1'b1;
                        end
                    end else begin
                        // Saturated count still follows the latest edge.
                        latest_edge_at = pos;
                    end
                end
                prev_sample = word[j];
            end
            if (next_word_index >= len - 1) begin
                summary.pad             = '0;
                summary.edge_count      = seen_edges;
                summary.any_edge        = (seen_edges != 0);
                summary.first_edge_pos  = (seen_edges != 0) ? first_edge_at : '0;
                summary.edge_span       = (seen_edges != 0) ?
                                          POS_W'(latest_edge_at - first_edge_at) : '0;
                summary.marked_found    = marked_hit;
                summary.marked_edge_pos = marked_hit ? marked_edge_at : '0;
                capture_summaries.push_back(summary);
                next_word_index = '0;
                prev_sample     = 1'b0;
                seen_edges      = '0;
                first_edge_at   = '0;
                latest_edge_at  = '0;
                marked_edge_at  = '0;
                marked_hit      = 1'b0;
            end else begin
                next_word_index = IDX_W'(next_word_index + 1);
            end
        end
    endtask

    // Sample content mixing random data with edge-dense and edge-free words.
    function automatic logic [WORD_W-1:0] sample_pattern();
        logic [WORD_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 8))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h5555_5555;
            3: return 32'hAAAA_AAAA;
            4: return 32'h1 << $urandom_range(0, 31);
            5: return ~(32'h1 << $urandom_range(0, 31));
            6: return r & $urandom & $urandom;
            7: return r | $urandom;
            default: return r;
        endcase
    endfunction

    // One APB transfer: setup cycle, then access until pready.
    task automatic reg_transfer(input logic idx, input logic is_write,
                                input logic [APB_DATA_W-1:0] data,
                                output logic [APB_DATA_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes a register, updates the predictor copy and reads the value back.
    task automatic reg_set(input logic idx, input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] rdata;
        logic [APB_DATA_W-1:0] stored;
        reg_transfer(idx, 1'b1, data, rdata);
        if (idx == sec_pkg::REG_CAPTURE_WORDS) begin
            cfg_capture_words = data[IDX_W-1:0];
            stored = {{(APB_DATA_W-IDX_W){1'b0}}, data[IDX_W-1:0]};
        end else begin
            cfg_marked_edge = data[CNT_W-1:0];
            stored = {{(APB_DATA_W-CNT_W){1'b0}}, data[CNT_W-1:0]};
        end
        reg_transfer(idx, 1'b0, '0, rdata);
        check_field("register readback", stored, rdata);
    endtask

    // Holds off until every queued word went in and every summary came out.
    task automatic wait_idle();
        while (sample_queue.size() != 0 || s_tvalid || capture_summaries.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Word sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                void'(sample_queue.pop_front());
                scan_word(s_tdata);
                if (burst_left > 0)
                    burst_left = burst_left - 1;
            end
            // A transaction on offer stays put until it is taken.
            if (!(s_tvalid && !s_tready)) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_queue[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Summary receiver: checks each transaction and stalls on a rotating pattern.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (capture_summaries.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    $display("%0t: summary expected none, got %0h", $time, m_tdata);
                end else begin
                    capture_summary_t want;
                    capture_summary_t got;
                    want = capture_summaries.pop_front();
                    got  = m_tdata;
                    check_field("edge_count", want.edge_count, got.edge_count);
                    check_field("any_edge", want.any_edge, got.any_edge);
                    check_field("first_edge_pos", want.first_edge_pos, got.first_edge_pos);
                    check_field("edge_span", want.edge_span, got.edge_span);
                    check_field("marked_found", want.marked_found, got.marked_found);
                    check_field("marked_edge_pos", want.marked_edge_pos,
                                got.marked_edge_pos);
                    check_field("padding", want.pad, got.pad);
                end
            end
            if (stall_cycles == 0) begin
                stall_cycles = 64;
                case ($urandom_range(0, 3))
                    0: stall_pattern = 16'hFFFF;
                    1: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
                    default: stall_pattern = 16'($urandom) | 16'h0001;
                endcase
            end
            stall_cycles = stall_cycles - 1;
            m_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // Stimulus: reset values, directed captures, a long capture cut short, random phases.
    initial begin
        logic [APB_DATA_W-1:0] rdata;
        logic [15:0]           len_value;
        logic [CNT_W-1:0]      mark_value;
        int                    phase;
        int                    n;
        int                    k;
        int                    phase_words;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        reg_transfer(sec_pkg::REG_CAPTURE_WORDS, 1'b0, '0, rdata);
        check_field("capture_words after reset", sec_pkg::CAPTURE_WORDS_RST, rdata);
        reg_transfer(sec_pkg::REG_MARKED_EDGE, 1'b0, '0, rdata);
        check_field("marked_edge_number after reset", sec_pkg::MARKED_EDGE_RST, rdata);

        // Start a long capture at the reset length, then shorten it under way.
        for (k = 0; k < 40; k++)
            sample_queue.push_back(sample_pattern());
        wait_idle();
        reg_set(sec_pkg::REG_CAPTURE_WORDS, 32'hFFFF_0003);
        sample_queue.push_back(sample_pattern());
        wait_idle();

        // Three-word captures: discarded word with edges, seeded high, single edge,
        // dense edges reaching the marked one, and a seed that is low.
        sample_queue = {sample_queue,
                        32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'h1234_5678, 32'h0000_0000, 32'h0000_0001,
                        32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                        32'h0000_0000, 32'hFFFF_FFFE, 32'h8000_0000};
        wait_idle();

        // A marked ordinal of zero never matches.
        reg_set(sec_pkg::REG_MARKED_EDGE, 32'h0000_0000);
        sample_queue = {sample_queue, 32'h0000_0000, 32'h5555_5555, 32'h5555_5555};
        wait_idle();

        // Lengths below two act as two.
        reg_set(sec_pkg::REG_MARKED_EDGE, 32'h0000_0001);
        reg_set(sec_pkg::REG_CAPTURE_WORDS, 32'h0000_0000);
        sample_queue = {sample_queue, 32'h0000_0000, 32'h0000_0002,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF};
        wait_idle();
        reg_set(sec_pkg::REG_CAPTURE_WORDS, 32'h0000_0001);
        sample_queue = {sample_queue, 32'h0000_0000, 32'h5555_5555};
        wait_idle();
        reg_set(sec_pkg::REG_MARKED_EDGE, 32'hFFFF_FFFF);
        reg_set(sec_pkg::REG_CAPTURE_WORDS, 32'h0000_0002);
        sample_queue = {sample_queue, 32'h0000_0000, 32'hAAAA_AAAA};
        wait_idle();

        // Largest length register value: a long capture, then cut short.
        reg_set(sec_pkg::REG_CAPTURE_WORDS, 32'h0000_FFFF);
        reg_set(sec_pkg::REG_MARKED_EDGE, 32'd1000);
        for (k = 0; k < 100; k++)
            sample_queue.push_back(($urandom_range(0, 9) < 7) ? 32'h5555_5555
                                                             : sample_pattern());
        wait_idle();
        reg_set(sec_pkg::REG_CAPTURE_WORDS, 32'h0000_0002);
        sample_queue.push_back(sample_pattern());
        wait_idle();

        // Random phases with short captures, some ending mid-capture.
        for (phase = 0; phase < 9; phase++) begin
            len_value = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(13, 64))
                                                    : 16'($urandom_range(0, 12));
            reg_set(sec_pkg::REG_CAPTURE_WORDS, {16'($urandom), len_value});
            case ($urandom_range(0, 3))
                0: mark_value = '0;
                1: mark_value = CNT_W'(1);
                2: mark_value = CNT_W'($urandom_range(2, 40));
                default: mark_value = CNT_W'($urandom_range(1, 16 * effective_length()));
            endcase
            reg_set(sec_pkg::REG_MARKED_EDGE, {12'($urandom), mark_value});
            n = words_to_close();
            phase_words = 0;
            while (phase_words < 100) begin
                for (k = 0; k < n; k++)
                    sample_queue.push_back(sample_pattern());
                phase_words = phase_words + n;
                n = effective_length();
            end
            if ($urandom_range(0, 1) == 1) begin
                n = $urandom_range(0, effective_length() - 1);
                for (k = 0; k < n; k++)
                    sample_queue.push_back(sample_pattern());
            end
            wait_idle();
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("sampled_edge_counter: match");
        else
            $display("sampled_edge_counter: mismatch");
        $finish;
    end

endmodule
